// ===== rtl/sentinel_sequence_stripper_unit_defines.svh =====
// Assertion macros shared by the stripper RTL.
// SSS_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// SSS_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef SENTINEL_SEQUENCE_STRIPPER_UNIT_DEFINES_SVH
`define SENTINEL_SEQUENCE_STRIPPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/sss_pkg.sv =====
package sss_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [CNT_W-1:0]     PAT_LEN   = 3'd4;
    localparam logic [BYTE_W-1:0]    PAT_EVEN  = 8'hFE;
    localparam logic [BYTE_W-1:0]    PAT_ODD   = 8'hFD;
    localparam logic [BYTE_W-1:0]    CODE_RISE = 8'h01;
    localparam logic [BYTE_W-1:0]    CODE_FALL = 8'h02;
    localparam logic [REG_IDX_W-1:0] REG_EVT_EN = 1'b0;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'b00,
        TAIL_DATA  = 2'b01,
        TAIL_EVENT = 2'b10
    } t_tail;

    // Sentinel alternates FE, FD, FE, FD.
    function automatic logic [BYTE_W-1:0] pat_byte(input logic odd);
        return odd ? PAT_ODD : PAT_EVEN;
    endfunction

endpackage

// ===== rtl/sss_in_if.sv =====
interface sss_in_if import sss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/sss_out_if.sv =====
interface sss_out_if import sss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_event;
    logic              event_rising;
    logic              last;

    modport source (output valid, output out_byte, output is_event, output event_rising,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input is_event, input event_rising,
                    input last, output ready);
endinterface

// ===== rtl/sentinel_sequence_stripper_unit.sv =====
// An accepted item is written into the job register; its results move from there into the
//   output register one at a time.
// Throughput: one item per cycle while each item yields at most one result and the output
//   is not stalled; an item that flushes a held prefix holds the job register for its up to 5 results.
// Reset (i_rst_n, synchronous, active low): match count, event enable and all valid
//   flags clear; payload registers are left as they are.
`include "sentinel_sequence_stripper_unit_defines.svh"

module sentinel_sequence_stripper_unit import sss_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sss_in_if.sink                i_in,
    sss_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic r_evt_en, n_evt_en;
    logic cfg_wr, cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_EVT_EN);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        n_evt_en = r_evt_en;
        if (cfg_wr && cfg_hit) begin
            n_evt_en = pwdata[0];
        end
    end

    assign prdata = cfg_hit ? {{(APB_DATA_W-1){1'b0}}, r_evt_en} : '0;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // Match state: how much of FE FD FE FD has been seen. Held bytes are
    // always the pattern prefix, so the count alone stands in for them.
    logic [CNT_W-1:0]  r_match_count, n_match_count;

    // Job register: the results still owed by one accepted item.
    // r_pre_left pattern bytes go out first, then the tail (data or event).
    logic              r_job_valid, n_job_valid;
    logic [CNT_W-1:0]  r_pre_left, n_pre_left;
    logic              r_pre_odd, n_pre_odd;
    t_tail             r_tail, n_tail;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_rising, n_rising;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_event, n_out_event;
    logic              r_out_rising, n_out_rising;
    logic              r_out_last, n_out_last;

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    logic job_fire, job_last, job_done, in_fire;

    // Move one result from the job into the output register whenever the
    // output register is empty or being taken this cycle.
    assign job_fire = r_job_valid && (!r_out_valid || o_out.ready);
    assign job_last = (r_pre_left == '0) ||
                      ((r_pre_left == CNT_W'(1)) && (r_tail == TAIL_NONE));
    assign job_done = job_fire && job_last;

    // Take a new item when the job register is free or empties this cycle.
    assign i_in.ready = !r_job_valid || job_done;
    assign in_fire    = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Decode of the incoming byte against the match state
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] b;
    logic [CNT_W-1:0]  acc_pre;
    t_tail             acc_tail;
    logic [CNT_W-1:0]  acc_count;
    logic              acc_has;
    logic              full_match;
    logic              is_code;

    assign b          = i_in.in_byte;
    assign full_match = (r_match_count >= PAT_LEN);
    assign is_code    = (b == CODE_RISE) || (b == CODE_FALL);

    always_comb begin
        acc_pre   = '0;
        acc_tail  = TAIL_NONE;
        acc_count = '0;
        if (!full_match) begin
            if (b == pat_byte(r_match_count[0])) begin
                // Extend the match; hold the byte.
                acc_count = r_match_count + CNT_W'(1);
            end else begin
                // Mismatch: release the held prefix.
                acc_pre = r_match_count;
                if (b == PAT_EVEN) begin
                    acc_count = CNT_W'(1);
                end else begin
                    acc_tail = TAIL_DATA;
                end
            end
        end else begin
            if (is_code) begin
                // Swallow the sentinel; report it only when enabled.
                acc_tail = r_evt_en ? TAIL_EVENT : TAIL_NONE;
            end else begin
                // Not a code: flush the whole pattern and the byte; even FE
                // does not restart a match here.
                acc_pre  = PAT_LEN;
                acc_tail = TAIL_DATA;
            end
        end
    end

    assign acc_has = (acc_pre != '0) || (acc_tail != TAIL_NONE);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        n_match_count = r_match_count;
        n_job_valid   = r_job_valid;
        n_pre_left    = r_pre_left;
        n_pre_odd     = r_pre_odd;
        n_tail        = r_tail;
        n_byte        = r_byte;
        n_rising      = r_rising;

        if (job_done) begin
            n_job_valid = 1'b0;
        end else if (job_fire) begin
            // Advance through the prefix.
            n_pre_left = r_pre_left - CNT_W'(1);
            n_pre_odd  = !r_pre_odd;
        end

        if (in_fire) begin
            n_match_count = acc_count;
            // Items that yield nothing never enter the job register.
            n_job_valid   = acc_has;
            n_pre_left    = acc_pre;
            n_pre_odd     = 1'b0;
            n_tail        = acc_tail;
            n_byte        = b;
            n_rising      = (b == CODE_RISE);
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_event  = r_out_event;
        n_out_rising = r_out_rising;
        n_out_last   = r_out_last;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (job_fire) begin
            n_out_valid = 1'b1;
            n_out_last  = job_last;
            if (r_pre_left != '0) begin
                n_out_byte   = pat_byte(r_pre_odd);
                n_out_event  = 1'b0;
                n_out_rising = 1'b0;
            end else begin
                case (r_tail)
                    TAIL_EVENT: begin
                        n_out_byte   = '0;
                        n_out_event  = 1'b1;
                        n_out_rising = r_rising;
                    end
                    default: begin
                        n_out_byte   = r_byte;
                        n_out_event  = 1'b0;
                        n_out_rising = 1'b0;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Flops
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_evt_en      <= 1'b0;
            r_match_count <= '0;
            r_job_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_evt_en      <= n_evt_en;
            r_match_count <= n_match_count;
            r_job_valid   <= n_job_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_left   <= n_pre_left;
        r_pre_odd    <= n_pre_odd;
        r_tail       <= n_tail;
        r_byte       <= n_byte;
        r_rising     <= n_rising;
        r_out_byte   <= n_out_byte;
        r_out_event  <= n_out_event;
        r_out_rising <= n_out_rising;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.is_event     = r_out_event;
    assign o_out.event_rising = r_out_rising;
    assign o_out.last         = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SSS_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1,
        r_match_count <= PAT_LEN, "match count above pattern length")
    `SSS_ASSERT_NOW(a_job_nonempty, i_clk, i_rst_n, r_job_valid,
        (r_pre_left != '0) || (r_tail != TAIL_NONE), "job register holds no result")
    `SSS_ASSERT_NOW(a_prefix_range, i_clk, i_rst_n, r_job_valid,
        r_pre_left <= PAT_LEN, "prefix count above pattern length")
    `SSS_ASSERT_NOW(a_event_shape, i_clk, i_rst_n, r_out_valid && r_out_event,
        r_out_last && (r_out_byte == '0), "event result not last or carries data")
    `SSS_ASSERT_NEXT(a_event_job, i_clk, i_rst_n, in_fire && full_match && is_code && r_evt_en,
        r_job_valid && (r_tail == TAIL_EVENT) && (r_pre_left == '0),
        "reported sentinel did not queue an event")

endmodule

// ===== tb/sv/tb_sentinel_sequence_stripper_unit.sv =====
module tb_sentinel_sequence_stripper_unit import sss_pkg::*; ();

    // Run limits: the cycle limit is several times the slowest correct run, in which every
    // result may meet output stalls and the input has gaps.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 77;
    localparam int NUM_PHASES    = 5;

    // Register index with nothing behind it; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 1'b1;

    // Directed run: FE FE, FE FD FE FE, then a full match closed by FE.
    localparam logic [9*BYTE_W-1:0] RESTART_RUN = {PAT_EVEN, PAT_EVEN, PAT_ODD, PAT_EVEN,
                                                   PAT_EVEN, PAT_ODD, PAT_EVEN, PAT_ODD,
                                                   PAT_EVEN};

    // Register settings for the random phases, phase 0 in the low slice.
    localparam logic [NUM_PHASES*REG_IDX_W-1:0] PHASE_IDX =
        {REG_EVT_EN, REG_EVT_EN, REG_EVT_EN, REG_UNUSED, REG_EVT_EN};
    localparam logic [NUM_PHASES*APB_DATA_W-1:0] PHASE_VAL =
        {32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_event;
        logic              event_rising;
        logic              last;
    } t_strip_res;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sss_in_if  in_bus ();
    sss_out_if out_bus ();

    sentinel_sequence_stripper_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stream bytes waiting to be offered, and results still owed by the block.
    logic [BYTE_W-1:0] tx_bytes [$];
    t_strip_res        expected_res [$];

    // Shadow of the block: sentinel bytes matched so far and event reporting.
    logic [CNT_W-1:0] held_cnt   = '0;
    logic             evt_report = 1'b0;

    // Handshake bookkeeping for the driver and the monitor; in_took is shared by both.
    logic in_took   = 1'b0;
    int   in_hold   = 0;
    int   out_hold  = 0;
    int   in_idle_pct  = 0;
    int   out_idle_pct = 0;
    int   cycle_cnt = 0;
    logic failed    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_strip_res data_res(input logic [BYTE_W-1:0] b);
        t_strip_res r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    // Work out the results one stream byte causes and queue them up.
    function automatic void predict_strip(input logic [BYTE_W-1:0] b);
        t_strip_res burst [$];
        t_strip_res ev;
        int k;
        if (held_cnt < PAT_LEN) begin
            if (b == (held_cnt[0] ? PAT_ODD : PAT_EVEN)) begin
                held_cnt = held_cnt + 1'b1;
            end else begin
                // Release the held prefix; FE then opens a fresh match.
                for (k = 0; k < held_cnt; k++)
                    burst.push_back(data_res(k[0] ? PAT_ODD : PAT_EVEN));
                if (b == PAT_EVEN) begin
                    held_cnt = 3'd1;
                end else begin
                    held_cnt = '0;
                    burst.push_back(data_res(b));
                end
            end
        end else begin
            // Full sentinel seen: a code swallows it, anything else flushes all.
            held_cnt = '0;
            if (b == CODE_RISE || b == CODE_FALL) begin
                if (evt_report) begin
                    ev = '0;
                    ev.is_event = 1'b1;
                    ev.event_rising = (b == CODE_RISE);
                    burst.push_back(ev);
                end
            end else begin
                for (k = 0; k < PAT_LEN; k++)
                    burst.push_back(data_res(k[0] ? PAT_ODD : PAT_EVEN));
                burst.push_back(data_res(b));
            end
        end
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[j])
            expected_res.push_back(burst[j]);
    endfunction

    // Favor the bytes the block cares about, but keep every value in play.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(9))
            0:       return PAT_EVEN;
            1:       return PAT_ODD;
            2:       return CODE_RISE;
            3:       return CODE_FALL;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void queue_sentinel(input logic [BYTE_W-1:0] code);
        tx_bytes.push_back(PAT_EVEN);
        tx_bytes.push_back(PAT_ODD);
        tx_bytes.push_back(PAT_EVEN);
        tx_bytes.push_back(PAT_ODD);
        tx_bytes.push_back(code);
    endfunction

    // Queue one chunk of stream: mostly whole sentinels with codes, then
    // broken prefixes and plain noise. Return the number of bytes queued.
    function automatic int queue_stream_chunk();
        int len;
        int k;
        len = 0;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                queue_sentinel($urandom_range(1) ? CODE_RISE : CODE_FALL);
                len = 5;
            end
            4: begin
                queue_sentinel(pick_byte());
                len = 5;
            end
            5, 6: begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    tx_bytes.push_back(k[0] ? PAT_ODD : PAT_EVEN);
                tx_bytes.push_back(pick_byte());
                len++;
            end
            default: begin
                len = $urandom_range(1, 4);
                repeat (len) tx_bytes.push_back(pick_byte());
            end
        endcase
        return len;
    endfunction

    function automatic void report_mismatch(input string fld, input logic [BYTE_W-1:0] want_v,
                                            input logic [BYTE_W-1:0] got_v);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, want_v, got_v);
        failed = 1'b1;
    endfunction

    // Write one register: setup cycle, then access until pready.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_EVT_EN)
            evt_report = val[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every byte is taken and every owed result has come, then
    // let the pipeline settle for bytes that caused no result.
    task automatic drain_stream();
        @(posedge i_clk);
        while (tx_bytes.size() != 0 || in_bus.valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: change inputs on the falling edge only.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid   <= 1'b0;
            in_bus.in_byte <= '0;
            out_bus.ready  <= 1'b0;
        end else begin
            // Input side: hold an offered byte until taken, else idle or advance.
            if (in_bus.valid && !in_took) begin
                // hold
            end else if (in_hold > 0) begin
                in_hold--;
                in_bus.valid <= 1'b0;
            end else if (tx_bytes.size() != 0 && $urandom_range(99) < in_idle_pct) begin
                in_hold = $urandom_range(15);
                in_bus.valid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                in_bus.valid   <= 1'b1;
                in_bus.in_byte <= tx_bytes.pop_front();
            end else begin
                in_bus.valid <= 1'b0;
            end

            // Output side: hold ready low in random bursts.
            if (out_hold > 0) begin
                out_hold--;
                out_bus.ready <= 1'b0;
            end else if ($urandom_range(99) < out_idle_pct) begin
                out_hold = $urandom_range(15);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Monitor: sample both handshakes on the rising edge.
    always @(posedge i_clk) begin : monitor
        t_strip_res got;
        t_strip_res want;

        in_took = i_rst_n && in_bus.valid && in_bus.ready;
        if (in_took)
            predict_strip(in_bus.in_byte);

        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.out_byte     = out_bus.out_byte;
            got.is_event     = out_bus.is_event;
            got.event_rising = out_bus.event_rising;
            got.last         = out_bus.last;
            if (expected_res.size() == 0) begin
                $display("%0t: result with none owed, expected nothing, got %0h", $time, got);
                failed = 1'b1;
            end else begin
                want = expected_res.pop_front();
                if (got.out_byte !== want.out_byte)
                    report_mismatch("out_byte", want.out_byte, got.out_byte);
                if (got.is_event !== want.is_event)
                    report_mismatch("is_event", want.is_event, got.is_event);
                if (got.event_rising !== want.event_rising)
                    report_mismatch("event_rising", want.event_rising, got.event_rising);
                if (got.last !== want.last)
                    report_mismatch("last", want.last, got.last);
            end
        end

        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int n;
        int ph;
        int k;

        // Park the register port and hold reset; the driver clears the stream
        // handshakes while reset is low.
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reporting off after reset: extremes of the byte, then a sentinel
        // with a code that must vanish without a result.
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        queue_sentinel(CODE_RISE);
        drain_stream();

        // Reporting on: both codes, then the restart cases.
        reg_write(REG_EVT_EN, 32'h0000_0001);
        queue_sentinel(CODE_RISE);
        queue_sentinel(CODE_FALL);
        for (k = 8; k >= 0; k--)
            tx_bytes.push_back(RESTART_RUN[k*BYTE_W +: BYTE_W]);
        drain_stream();

        // Random phases, each under its own register setting and idle mix.
        // Drop all idling in the last phase.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            reg_write(PHASE_IDX[ph*REG_IDX_W +: REG_IDX_W],
                      PHASE_VAL[ph*APB_DATA_W +: APB_DATA_W]);
            if (ph == NUM_PHASES - 1) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 15 * $urandom_range(2);
                out_idle_pct = 15 * $urandom_range(2);
            end
            n = 0;
            while (n < PHASE_ITEMS)
                n += queue_stream_chunk();
            drain_stream();
        end

        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
